[design/lsbse_pkg.sv]
// ----------------------------------------------------------------------------
// lsbse_pkg
// Shared types, register map and reset constants of the LSB extractor core.
// ----------------------------------------------------------------------------
package lsbse_pkg;

   // field widths
   localparam int BYTE_W   = 8;
   localparam int KIND_W   = 3;
   localparam int SIZE_W   = 32;
   localparam int SKIP_W   = 10;
   localparam int MAGIC_W  = 16;
   localparam int BITCNT_W = 3;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic [0:0] reg_idx_type;
   localparam reg_idx_type REG_HEADER_SKIP = 1'b0;
   localparam reg_idx_type REG_MAGIC_WORD  = 1'b1;

   // register reset values ("#*" for the magic characters)
   localparam logic [SKIP_W-1:0]  HEADER_SKIP_RESET = 10'd54;
   localparam logic [MAGIC_W-1:0] MAGIC_WORD_RESET  = 16'h232A;

   // last bit position of a hidden byte
   localparam logic [BITCNT_W-1:0] BIT_LAST = 3'd7;

   // bytes in the payload length field
   localparam logic [BYTE_W-1:0] SIZE_BYTES = 8'd4;

   // parsing phases
   typedef enum logic [2:0] {
      PH_SKIP   = 3'd0,
      PH_MAGIC  = 3'd1,
      PH_EXTLEN = 3'd2,
      PH_EXT    = 3'd3,
      PH_SIZE   = 3'd4,
      PH_DATA   = 3'd5,
      PH_DONE   = 3'd6
   } phase_type;

   // result kinds
   typedef enum logic [KIND_W-1:0] {
      K_MAGIC_OK  = 3'd0,
      K_MAGIC_BAD = 3'd1,
      K_EXT       = 3'd2,
      K_SIZE      = 3'd3,
      K_DATA      = 3'd4,
      K_EMPTY     = 3'd5
   } kind_type;

   // live configuration
   typedef struct packed {
      logic [SKIP_W-1:0]  header_skip;
      logic [MAGIC_W-1:0] magic_word;
   } cfg_type;

   // one result item
   typedef struct packed {
      kind_type            kind;
      logic [BYTE_W-1:0]   value;
      logic [SIZE_W-1:0]   payload_size;
      logic                last;
   } result_type;

endpackage

[design/lsbse_req_if.sv]
// ----------------------------------------------------------------------------
// lsbse_req_if
// Carrier byte channel: valid/ready handshake with one file byte per item.
// ----------------------------------------------------------------------------
interface lsbse_req_if;
   import lsbse_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] carrier_byte;
   logic              first;

   modport source (output valid, output carrier_byte, output first, input ready);
   modport sink   (input valid, input carrier_byte, input first, output ready);
endinterface

[design/lsbse_rsp_if.sv]
// ----------------------------------------------------------------------------
// lsbse_rsp_if
// Decoded result channel: valid/ready handshake with one result per item.
// ----------------------------------------------------------------------------
interface lsbse_rsp_if;
   import lsbse_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [BYTE_W-1:0] value;
   logic [SIZE_W-1:0] payload_size;
   logic              last;

   modport source (output valid, output kind, output value, output payload_size,
                   output last, input ready);
   modport sink   (input valid, input kind, input value, input payload_size,
                   input last, output ready);
endinterface

[design/lsbse_csr.sv]
// ----------------------------------------------------------------------------
// lsbse_csr
// APB-style register file holding the header skip count and the magic word.
// ----------------------------------------------------------------------------
module lsbse_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [lsbse_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lsbse_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lsbse_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready,
   output lsbse_pkg::cfg_type               cfg
);
   import lsbse_pkg::*;

   logic [SKIP_W-1:0]  header_skip_ff;
   logic [MAGIC_W-1:0] magic_word_ff;
   reg_idx_type        reg_idx;
   logic               wr_en;

   // word address selects the register
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1 -: 1];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         header_skip_ff <= HEADER_SKIP_RESET;
         magic_word_ff  <= MAGIC_WORD_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            REG_HEADER_SKIP: header_skip_ff <= csr_pwdata[SKIP_W-1:0];
            REG_MAGIC_WORD:  magic_word_ff  <= csr_pwdata[MAGIC_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_HEADER_SKIP: csr_prdata = {{(CSR_DATA_W-SKIP_W){1'b0}}, header_skip_ff};
         REG_MAGIC_WORD:  csr_prdata = {{(CSR_DATA_W-MAGIC_W){1'b0}}, magic_word_ff};
         default:         csr_prdata = '0;
      endcase
   end

   assign cfg.header_skip = header_skip_ff;
   assign cfg.magic_word  = magic_word_ff;
endmodule

[design/lsbse_parser.sv]
// ----------------------------------------------------------------------------
// lsbse_parser
// Parsing state and the per-byte step: gathers LSBs into hidden bytes and
// walks the magic, extension, size and payload fields.
// ----------------------------------------------------------------------------
module lsbse_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [lsbse_pkg::BYTE_W-1:0] carrier_byte,
   input  logic                         first,
   input  lsbse_pkg::cfg_type           cfg,
   output logic                         res_valid,
   output lsbse_pkg::result_type        res
);
   import lsbse_pkg::*;

   // state registers
   phase_type           phase_ff, phase_in;
   logic [SKIP_W-1:0]   header_count_ff, header_count_in;
   logic [BITCNT_W-1:0] bit_count_ff, bit_count_in;
   logic [BYTE_W-1:0]   bit_shift_ff, bit_shift_in;
   logic [BYTE_W-1:0]   field_count_ff, field_count_in;
   logic [BYTE_W-1:0]   first_magic_ff, first_magic_in;
   logic [BYTE_W-1:0]   ext_len_ff, ext_len_in;
   logic [SIZE_W-1:0]   size_accum_ff, size_accum_in;
   logic [SIZE_W-1:0]   remaining_ff, remaining_in;

   // state as seen by this item (cleared when first is set)
   phase_type           ph_cur;
   logic [SKIP_W-1:0]   hc_cur;
   logic [BITCNT_W-1:0] bc_cur;
   logic [BYTE_W-1:0]   bs_cur;
   logic [BYTE_W-1:0]   fc_cur;
   logic [BYTE_W-1:0]   fm_cur;
   logic [BYTE_W-1:0]   el_cur;
   logic [SIZE_W-1:0]   sa_cur;
   logic [SIZE_W-1:0]   rem_cur;

   // shared step terms
   logic                skipping;
   phase_type           ph_work;
   logic [BYTE_W-1:0]   hb;
   logic                byte_done;
   logic [BYTE_W-1:0]   fc_inc;
   logic [SIZE_W-1:0]   size_new;
   logic [SIZE_W-1:0]   rem_dec;

   // restart on first byte of a file
   assign ph_cur  = first ? PH_SKIP : phase_ff;
   assign hc_cur  = first ? '0 : header_count_ff;
   assign bc_cur  = first ? '0 : bit_count_ff;
   assign bs_cur  = first ? '0 : bit_shift_ff;
   assign fc_cur  = first ? '0 : field_count_ff;
   assign fm_cur  = first ? '0 : first_magic_ff;
   assign el_cur  = first ? '0 : ext_len_ff;
   assign sa_cur  = first ? '0 : size_accum_ff;
   assign rem_cur = first ? '0 : remaining_ff;

   assign skipping  = (ph_cur == PH_SKIP) && (hc_cur < cfg.header_skip);
   assign ph_work   = (ph_cur == PH_SKIP) ? PH_MAGIC : ph_cur;
   assign hb        = {bs_cur[BYTE_W-2:0], carrier_byte[0]};
   assign byte_done = (bc_cur == BIT_LAST);
   assign fc_inc    = fc_cur + 8'd1;
   assign size_new  = {sa_cur[SIZE_W-BYTE_W-1:0], hb};
   assign rem_dec   = rem_cur - 32'd1;

   // next state
   always_comb begin
      phase_in        = ph_cur;
      header_count_in = hc_cur;
      bit_count_in    = bc_cur;
      bit_shift_in    = bs_cur;
      field_count_in  = fc_cur;
      first_magic_in  = fm_cur;
      ext_len_in      = el_cur;
      size_accum_in   = sa_cur;
      remaining_in    = rem_cur;
      if (ph_cur == PH_DONE) begin
         phase_in = PH_DONE;
      end else if (skipping) begin
         header_count_in = hc_cur + 10'd1;
      end else if (!byte_done) begin
         phase_in     = ph_work;
         bit_shift_in = hb;
         bit_count_in = bc_cur + 3'd1;
      end else begin
         phase_in     = ph_work;
         bit_shift_in = '0;
         bit_count_in = '0;
         case (ph_work)
            PH_MAGIC: begin
               if (fc_cur == '0) begin
                  first_magic_in = hb;
                  field_count_in = 8'd1;
               end else begin
                  field_count_in = '0;
                  phase_in       = PH_EXTLEN;
               end
            end
            PH_EXTLEN: begin
               ext_len_in     = hb;
               field_count_in = '0;
               phase_in       = (hb == '0) ? PH_SIZE : PH_EXT;
            end
            PH_EXT: begin
               if (fc_inc >= el_cur) begin
                  field_count_in = '0;
                  phase_in       = PH_SIZE;
               end else begin
                  field_count_in = fc_inc;
               end
            end
            PH_SIZE: begin
               size_accum_in = size_new;
               if (fc_inc >= SIZE_BYTES) begin
                  field_count_in = '0;
                  remaining_in   = size_new;
                  phase_in       = (size_new == '0) ? PH_DONE : PH_DATA;
               end else begin
                  field_count_in = fc_inc;
               end
            end
            PH_DATA: begin
               remaining_in = rem_dec;
               if (rem_dec == '0) begin
                  phase_in = PH_DONE;
               end
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase
      end
   end

   // result of this item
   always_comb begin
      res_valid        = 1'b0;
      res.kind         = K_EXT;
      res.value        = '0;
      res.payload_size = '0;
      res.last         = 1'b0;
      if ((ph_cur != PH_DONE) && !skipping && byte_done) begin
         case (ph_work)
            PH_MAGIC: begin
               if (fc_cur != '0) begin
                  res_valid = 1'b1;
                  res.kind  = ({fm_cur, hb} == cfg.magic_word) ? K_MAGIC_OK
                                                               : K_MAGIC_BAD;
               end
            end
            PH_EXT: begin
               res_valid = 1'b1;
               res.kind  = K_EXT;
               res.value = hb;
            end
            PH_SIZE: begin
               if (fc_inc >= SIZE_BYTES) begin
                  res_valid = 1'b1;
                  if (size_new == '0) begin
                     res.kind = K_EMPTY;
                  end else begin
                     res.kind         = K_SIZE;
                     res.payload_size = size_new;
                  end
               end
            end
            PH_DATA: begin
               res_valid = 1'b1;
               res.kind  = K_DATA;
               res.value = hb;
               res.last  = (rem_dec == '0);
            end
            default: ;
         endcase
      end
   end

   // state update on each processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_SKIP;
         header_count_ff <= '0;
         bit_count_ff    <= '0;
         bit_shift_ff    <= '0;
         field_count_ff  <= '0;
         first_magic_ff  <= '0;
         ext_len_ff      <= '0;
         size_accum_ff   <= '0;
         remaining_ff    <= '0;
      end else if (step) begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         bit_count_ff    <= bit_count_in;
         bit_shift_ff    <= bit_shift_in;
         field_count_ff  <= field_count_in;
         first_magic_ff  <= first_magic_in;
         ext_len_ff      <= ext_len_in;
         size_accum_ff   <= size_accum_in;
         remaining_ff    <= remaining_in;
      end
   end
endmodule

[design/lsb_stego_extractor_core.sv]
// ----------------------------------------------------------------------------
// lsb_stego_extractor_core
// Recovers a message hidden in the least significant bits of a carrier file.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one carrier file byte per item; first marks the first byte
//   of a file and restarts parsing. Each byte goes into an input register,
//   is processed once the result register is free or being emptied, and its
//   result, if any, lands in the output register on rsp_ch (kind, value,
//   payload_size, last). One item per cycle is sustained while rsp_ch accepts
//   results, set by the single parse step between the input and result
//   registers. Most bytes give no result (header bytes, the first seven bits
//   of each hidden byte, the first magic byte, the extension length byte and
//   all but the last size byte).
//   If rsp_ch stalls, the input register holds one more item and req_ch
//   ready drops only once both registers are full.
//   The csr_ port sets the header skip count (address 0) and the magic word
//   (address 4); write only while the core is idle.
//   Synchronous reset empties both registers, restores the register defaults
//   (skip 54, magic "#*") and returns parsing to the header skip phase.
// ----------------------------------------------------------------------------
module lsb_stego_extractor_core (
   input  logic                             clock,
   input  logic                             reset,
   lsbse_req_if.sink                        req_ch,
   lsbse_rsp_if.source                      rsp_ch,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [lsbse_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lsbse_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lsbse_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);
   import lsbse_pkg::*;

   cfg_type           cfg;
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_first_ff;
   logic              out_valid_ff;
   result_type        out_ff;
   logic              step;
   logic              res_valid;
   result_type        res;

   // register file
   lsbse_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // process the held item when the result register frees up
   assign step         = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || step;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_byte_ff  <= req_ch.carrier_byte;
         in_first_ff <= req_ch.first;
      end
   end

   // parse step
   lsbse_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .carrier_byte (in_byte_ff),
      .first        (in_first_ff),
      .cfg          (cfg),
      .res_valid    (res_valid),
      .res          (res)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= res_valid;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.kind         = out_ff.kind;
   assign rsp_ch.value        = out_ff.value;
   assign rsp_ch.payload_size = out_ff.payload_size;
   assign rsp_ch.last         = out_ff.last;
endmodule
